[rtl/cpde_pkg.sv]
// Shared constants and types of the chunked patch delta encoder.
`default_nettype none

package cpde_pkg;

	localparam int unsigned CHUNK_BYTES_DEF = 64;
	localparam int unsigned OFFSET_W        = 40;
	localparam int unsigned BYTE_W          = 8;

	// result queue in the back end
	localparam int unsigned OQ_DEPTH = 4;
	localparam int unsigned OQ_PTR_W = 2;
	localparam int unsigned OQ_CNT_W = 3;

	// back end hands a chunk buffer bank back to the front end
	typedef struct packed {
		logic valid;
		logic bank;
	} bank_rel_t;

	typedef enum logic {
		BK_IDLE,
		BK_RUN
	} back_state_t;

endpackage

`default_nettype wire

[rtl/chunked_patch_delta_encoder_core.sv]
// Top level of the chunked patch delta encoder: front end, descriptor queue, chunk RAM, back end.
// Throughput: one byte pair per cycle in; a differing chunk drains at one result per cycle, set
//   by the single RAM read port of the back end, while the result queue has room; the back end
//   passes through its idle state between chunks.
// Input stalls (full) only while both chunk banks hold chunks not yet drained.
// Reset (arst_n low) clears all control state and base_offset; the chunk RAM is not cleared.
`default_nettype none

module chunked_patch_delta_encoder_core #(
	parameter int unsigned CHUNK_BYTES = cpde_pkg::CHUNK_BYTES_DEF,
	// derived, not to be overridden
	parameter int unsigned SIZE_W      = $clog2(CHUNK_BYTES + 1)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// input queue side
	input  wire logic                          push,
	output logic                               full,
	input  wire logic [cpde_pkg::BYTE_W-1:0]   new_byte,
	input  wire logic [cpde_pkg::BYTE_W-1:0]   old_byte,
	input  wire logic                          end_of_file,
	// base_offset register
	input  wire logic                          cfg_wr_en,
	input  wire logic [cpde_pkg::OFFSET_W-1:0] cfg_wr_data,
	// result queue side
	output logic                               empty,
	input  wire logic                          pop,
	output logic      [cpde_pkg::OFFSET_W-1:0] chunk_offset,
	output logic      [SIZE_W-1:0]             chunk_size,
	output logic      [cpde_pkg::BYTE_W-1:0]   patch_byte,
	output logic      [cpde_pkg::BYTE_W-1:0]   backup_byte,
	output logic                               last_of_record
);

	// Byte index within a chunk; at least one bit so a one-byte chunk still addresses.
	localparam int unsigned IDX_W  = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
	// Descriptor: chunk offset, chunk size, bank holding the bytes.
	localparam int unsigned DESC_W = cpde_pkg::OFFSET_W + SIZE_W + 1;
	localparam int unsigned DATA_W = 2 * cpde_pkg::BYTE_W;

	logic                ram_wr_en;
	logic [IDX_W:0]      ram_wr_addr;
	logic [DATA_W-1:0]   ram_wr_data;
	logic [IDX_W:0]      ram_rd_addr;
	logic [DATA_W-1:0]   ram_rd_data;

	logic                desc_push;
	logic [DESC_W-1:0]   desc_wr_data;
	logic                desc_pop;
	logic                desc_empty;
	logic [DESC_W-1:0]   desc_rd_data;

	cpde_pkg::bank_rel_t rel;

	// Front end: writes each byte pair into the open bank and, when a chunk closes
	// (full chunk or end of file) with any byte changed, posts one descriptor
	// transaction. An unchanged chunk simply reuses its bank.
	cpde_front #(
		.CHUNK_BYTES (CHUNK_BYTES),
		.IDX_W       (IDX_W),
		.SIZE_W      (SIZE_W),
		.DESC_W      (DESC_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.new_byte    (new_byte),
		.old_byte    (old_byte),
		.end_of_file (end_of_file),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.rel         (rel),
		.ram_wr_en   (ram_wr_en),
		.ram_wr_addr (ram_wr_addr),
		.ram_wr_data (ram_wr_data),
		.desc_push   (desc_push),
		.desc_data   (desc_wr_data)
	);

	// Two banks of CHUNK_BYTES byte pairs: the front fills one while the back
	// drains the other.
	cpde_chunk_ram #(
		.ADDR_W (IDX_W + 1),
		.DATA_W (DATA_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// Descriptor queue; two entries match the two banks, so it never overflows.
	cpde_desc_fifo #(
		.W (DESC_W)
	) u_desc_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (desc_push),
		.wr_data (desc_wr_data),
		.rd_en   (desc_pop),
		.empty   (desc_empty),
		.rd_data (desc_rd_data)
	);

	// Back end: reads the chunk out one byte a cycle while the result queue has room and queues
	// the results; the bank goes back to the front end once its last byte has been read.
	cpde_back #(
		.IDX_W  (IDX_W),
		.SIZE_W (SIZE_W),
		.DESC_W (DESC_W)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.desc_empty     (desc_empty),
		.desc_data      (desc_rd_data),
		.desc_pop       (desc_pop),
		.ram_rd_addr    (ram_rd_addr),
		.ram_rd_data    (ram_rd_data),
		.rel            (rel),
		.pop            (pop),
		.empty          (empty),
		.chunk_offset   (chunk_offset),
		.chunk_size     (chunk_size),
		.patch_byte     (patch_byte),
		.backup_byte    (backup_byte),
		.last_of_record (last_of_record)
	);

endmodule

`default_nettype wire

[rtl/cpde_chunk_ram.sv]
// Two-bank chunk buffer: one write port, one registered read port.
`default_nettype none

module cpde_chunk_ram #(
	parameter int unsigned ADDR_W = 7,
	parameter int unsigned DATA_W = 16
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [DATA_W-1:0] wr_data,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem_q [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

[rtl/cpde_desc_fifo.sv]
// Two-entry queue of closed-chunk descriptors between front and back end.
`default_nettype none

module cpde_desc_fifo #(
	parameter int unsigned W = 48
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         wr_en,
	input  wire logic [W-1:0] wr_data,
	input  wire logic         rd_en,
	output logic              empty,
	output logic      [W-1:0] rd_data
);

	logic [W-1:0] mem_q [2];
	logic         wp_q;
	logic         rp_q;
	logic [1:0]   cnt_q;

	assign empty   = (cnt_q == 2'd0);
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) begin
				wp_q <= ~wp_q;
			end
			if (rd_en) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(wr_en) - 2'(rd_en);
		end
	end

endmodule

`default_nettype wire

[rtl/cpde_front.sv]
// Front end: takes byte pairs, fills chunk banks, posts descriptors of differing chunks.
`default_nettype none

module cpde_front #(
	parameter int unsigned CHUNK_BYTES = cpde_pkg::CHUNK_BYTES_DEF,
	parameter int unsigned IDX_W       = 6,
	parameter int unsigned SIZE_W      = 7,
	parameter int unsigned DESC_W      = 48
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	output logic                             full,
	input  wire logic [cpde_pkg::BYTE_W-1:0] new_byte,
	input  wire logic [cpde_pkg::BYTE_W-1:0] old_byte,
	input  wire logic                        end_of_file,
	input  wire logic                        cfg_wr_en,
	input  wire logic [cpde_pkg::OFFSET_W-1:0] cfg_wr_data,
	input  wire cpde_pkg::bank_rel_t         rel,
	output logic                             ram_wr_en,
	output logic      [IDX_W:0]              ram_wr_addr,
	output logic      [2*cpde_pkg::BYTE_W-1:0] ram_wr_data,
	output logic                             desc_push,
	output logic      [DESC_W-1:0]           desc_data
);

	localparam int unsigned OW = cpde_pkg::OFFSET_W;

	logic [IDX_W-1:0] fill_q;
	logic             bank_q;
	logic             differs_q;
	logic [OW-1:0]    file_index_q;
	logic [OW-1:0]    start_q;
	logic [OW-1:0]    base_q;
	logic [1:0]       busy_q;

	logic             acc;
	logic             differs_now;
	logic             closing;
	logic [OW-1:0]    start_cur;
	logic [OW-1:0]    chunk_off;
	logic [SIZE_W-1:0] chunk_sz;
	logic [1:0]       busy_set;
	logic [1:0]       busy_clr;

	// a bank still being drained by the back end cannot be refilled
	assign full = busy_q[bank_q];
	assign acc  = push && !full;

	assign differs_now = differs_q || (new_byte != old_byte);
	assign closing     = end_of_file || (fill_q == IDX_W'(CHUNK_BYTES - 1));
	assign start_cur   = (fill_q == '0) ? file_index_q : start_q;
	assign chunk_off   = base_q + start_cur;
	assign chunk_sz    = SIZE_W'(fill_q) + SIZE_W'(1);

	assign ram_wr_en   = acc;
	assign ram_wr_addr = {bank_q, fill_q};
	assign ram_wr_data = {new_byte, old_byte};

	assign desc_push = acc && closing && differs_now;
	assign desc_data = {chunk_off, chunk_sz, bank_q};

	assign busy_clr = rel.valid ? (2'b01 << rel.bank) : 2'b00;
	assign busy_set = desc_push ? (2'b01 << bank_q) : 2'b00;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_wr_en) begin
			base_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q       <= '0;
			bank_q       <= 1'b0;
			differs_q    <= 1'b0;
			file_index_q <= '0;
			start_q      <= '0;
		end else if (acc) begin
			start_q <= start_cur;
			if (closing) begin
				fill_q    <= '0;
				differs_q <= 1'b0;
			end else begin
				fill_q    <= fill_q + IDX_W'(1);
				differs_q <= differs_now;
			end
			if (desc_push) begin
				bank_q <= ~bank_q;
			end
			if (end_of_file) begin
				file_index_q <= '0;
			end else begin
				file_index_q <= file_index_q + OW'(1);
			end
		end
	end

	// set and release never hit the same bank in one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 2'b00;
		end else begin
			busy_q <= (busy_q & ~busy_clr) | busy_set;
		end
	end

endmodule

`default_nettype wire

[rtl/cpde_back.sv]
// Back end: drains a differing chunk into the result queue, one result per cycle unless full.
`default_nettype none

module cpde_back #(
	parameter int unsigned IDX_W  = 6,
	parameter int unsigned SIZE_W = 7,
	parameter int unsigned DESC_W = 48
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          desc_empty,
	input  wire logic [DESC_W-1:0]             desc_data,
	output logic                               desc_pop,
	output logic      [IDX_W:0]                ram_rd_addr,
	input  wire logic [2*cpde_pkg::BYTE_W-1:0] ram_rd_data,
	output cpde_pkg::bank_rel_t                rel,
	input  wire logic                          pop,
	output logic                               empty,
	output logic      [cpde_pkg::OFFSET_W-1:0] chunk_offset,
	output logic      [SIZE_W-1:0]             chunk_size,
	output logic      [cpde_pkg::BYTE_W-1:0]   patch_byte,
	output logic      [cpde_pkg::BYTE_W-1:0]   backup_byte,
	output logic                               last_of_record
);

	localparam int unsigned OW  = cpde_pkg::OFFSET_W;
	localparam int unsigned BW  = cpde_pkg::BYTE_W;
	localparam int unsigned PW  = cpde_pkg::OQ_PTR_W;
	localparam int unsigned CW  = cpde_pkg::OQ_CNT_W;
	localparam int unsigned OQD = cpde_pkg::OQ_DEPTH;

	cpde_pkg::back_state_t state_q, state_d;

	logic              bank_q;
	logic [IDX_W-1:0]  k_q;
	logic [SIZE_W-1:0] size_q;
	logic [OW-1:0]     off_q;

	logic              v_s1;
	logic              last_s1;
	logic [SIZE_W-1:0] size_s1;
	logic [OW-1:0]     off_s1;

	logic [OW-1:0]     oq_off_q  [OQD];
	logic [SIZE_W-1:0] oq_size_q [OQD];
	logic [BW-1:0]     oq_new_q  [OQD];
	logic [BW-1:0]     oq_old_q  [OQD];
	logic              oq_last_q [OQD];
	logic [PW-1:0]     wp_q;
	logic [PW-1:0]     rp_q;
	logic [CW-1:0]     ocnt_q;

	logic issue;
	logic last_issue;
	logic out_pop;

	// room for the read in flight as well as the one issued now
	assign issue      = (state_q == cpde_pkg::BK_RUN) &&
	                    ((ocnt_q + CW'(v_s1)) < CW'(OQD));
	assign last_issue = issue && ((SIZE_W'(k_q) + SIZE_W'(1)) == size_q);
	assign ram_rd_addr = {bank_q, k_q};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cpde_pkg::BK_IDLE: begin
				if (!desc_empty) begin
					state_d = cpde_pkg::BK_RUN;
				end
			end
			cpde_pkg::BK_RUN: begin
				if (last_issue) begin
					state_d = cpde_pkg::BK_IDLE;
				end
			end
			default: state_d = cpde_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		desc_pop  = (state_q == cpde_pkg::BK_IDLE) && !desc_empty;
		rel.valid = last_issue;
		rel.bank  = bank_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cpde_pkg::BK_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			if (desc_pop) begin
				k_q <= '0;
			end else if (issue) begin
				k_q <= k_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (desc_pop) begin
			{off_q, size_q, bank_q} <= desc_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			last_s1 <= last_issue;
			size_s1 <= size_q;
			off_s1  <= off_q;
		end
	end

	// result queue
	assign empty   = (ocnt_q == '0);
	assign out_pop = pop && !empty;

	assign chunk_offset   = oq_off_q[rp_q];
	assign chunk_size     = oq_size_q[rp_q];
	assign patch_byte     = oq_new_q[rp_q];
	assign backup_byte    = oq_old_q[rp_q];
	assign last_of_record = oq_last_q[rp_q];

	always_ff @(posedge clk) begin
		if (v_s1) begin
			oq_off_q[wp_q]  <= off_s1;
			oq_size_q[wp_q] <= size_s1;
			oq_new_q[wp_q]  <= ram_rd_data[2*BW-1:BW];
			oq_old_q[wp_q]  <= ram_rd_data[BW-1:0];
			oq_last_q[wp_q] <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			rp_q   <= '0;
			ocnt_q <= '0;
		end else begin
			if (v_s1) begin
				wp_q <= wp_q + PW'(1);
			end
			if (out_pop) begin
				rp_q <= rp_q + PW'(1);
			end
			ocnt_q <= ocnt_q + CW'(v_s1) - CW'(out_pop);
		end
	end

endmodule

`default_nettype wire

[rtl/cpde_checker.sv]
// Port-level checker for the chunked patch delta encoder, bound to its top level.
`default_nettype none

module cpde_checker #(
	parameter int unsigned CHUNK_BYTES = cpde_pkg::CHUNK_BYTES_DEF,
	parameter int unsigned SIZE_W      = $clog2(CHUNK_BYTES + 1)
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          empty,
	input wire logic                          pop,
	input wire logic [cpde_pkg::OFFSET_W-1:0] chunk_offset,
	input wire logic [SIZE_W-1:0]             chunk_size,
	input wire logic [cpde_pkg::BYTE_W-1:0]   patch_byte,
	input wire logic [cpde_pkg::BYTE_W-1:0]   backup_byte,
	input wire logic                          last_of_record
);

	// waiting result holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(chunk_offset) && $stable(chunk_size) &&
		$stable(patch_byte) && $stable(backup_byte) && $stable(last_of_record))
		else $error("result changed while stalled");

	a_size_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (chunk_size != '0) && (chunk_size <= SIZE_W'(CHUNK_BYTES)))
		else $error("chunk size out of range");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (chunk_size == SIZE_W'(1)) |-> last_of_record)
		else $error("one-byte record without last flag");

	// within a record offset and size do not change
	a_record_const: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !empty && !last_of_record |=> empty ||
		(chunk_offset == $past(chunk_offset) && chunk_size == $past(chunk_size)))
		else $error("record header changed mid-record");

endmodule

bind chunked_patch_delta_encoder_core cpde_checker #(
	.CHUNK_BYTES (CHUNK_BYTES),
	.SIZE_W      (SIZE_W)
) u_cpde_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.empty          (empty),
	.pop            (pop),
	.chunk_offset   (chunk_offset),
	.chunk_size     (chunk_size),
	.patch_byte     (patch_byte),
	.backup_byte    (backup_byte),
	.last_of_record (last_of_record)
);

`default_nettype wire

[verif/chunked_patch_delta_encoder_core_tb.sv]
// Self-checking testbench of the chunked patch delta encoder core.

module chunked_patch_delta_encoder_core_tb;

	localparam int unsigned BYTE_W     = cpde_pkg::BYTE_W;
	localparam int unsigned OFFSET_W   = cpde_pkg::OFFSET_W;
	localparam int unsigned CHUNK      = cpde_pkg::CHUNK_BYTES_DEF;
	localparam int unsigned SIZE_BITS  = $clog2(CHUNK + 1);
	// first record byte shows only after the descriptor queue and back end; leave margin
	localparam int          SETTLE_CYC = 8;
	// byte pairs per random phase, roughly
	localparam int unsigned PHASE_LEN  = 40;
	localparam int          N_PHASES   = 5;
	localparam int          CLK_HALF   = 6;
	localparam int          RUN_LIMIT  = 2 * CLK_HALF * 200000;

	typedef struct packed {
		logic [BYTE_W-1:0] new_b;
		logic [BYTE_W-1:0] old_b;
		logic              eof;
	} byte_pair_t;

	typedef struct packed {
		logic [OFFSET_W-1:0]  offset;
		logic [SIZE_BITS-1:0] size;
		logic [BYTE_W-1:0]    patch;
		logic [BYTE_W-1:0]    backup;
		logic                 last;
	} record_t;

	// how the content of a generated file relates new and old bytes
	typedef enum int unsigned {
		STYLE_SAME,     // every pair matches, chunk stays silent
		STYLE_ONE_DIFF, // a single differing pair somewhere
		STYLE_NOISE,    // independent bytes, nearly every pair differs
		STYLE_SPARSE    // about one pair in eight differs
	} file_style_t;

	// receiver behaviour, redrawn at random whenever the current mode runs out
	typedef enum int unsigned {
		DRAIN_FULL,
		DRAIN_HALF,
		DRAIN_SPARSE,
		DRAIN_HOLD
	} drain_mode_t;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  push        = 1'b0;
	logic                  full;
	logic [BYTE_W-1:0]     new_byte    = '0;
	logic [BYTE_W-1:0]     old_byte    = '0;
	logic                  end_of_file = 1'b0;
	logic                  cfg_wr_en   = 1'b0;
	logic [OFFSET_W-1:0]   cfg_wr_data = '0;
	logic                  empty;
	logic                  pop         = 1'b0;
	logic [OFFSET_W-1:0]   chunk_offset;
	logic [SIZE_BITS-1:0]  chunk_size;
	logic [BYTE_W-1:0]     patch_byte;
	logic [BYTE_W-1:0]     backup_byte;
	logic                  last_of_record;

	chunked_patch_delta_encoder_core u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.new_byte       (new_byte),
		.old_byte       (old_byte),
		.end_of_file    (end_of_file),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.empty          (empty),
		.pop            (pop),
		.chunk_offset   (chunk_offset),
		.chunk_size     (chunk_size),
		.patch_byte     (patch_byte),
		.backup_byte    (backup_byte),
		.last_of_record (last_of_record)
	);

	always #CLK_HALF clk = ~clk;

	// ---- encoder image: open chunk, file position, base offset ----
	logic [BYTE_W-1:0]   new_img [CHUNK];
	logic [BYTE_W-1:0]   old_img [CHUNK];
	int unsigned         fill_cnt = 0;
	logic [OFFSET_W-1:0] file_pos = '0;
	logic                any_diff = 1'b0;
	logic [OFFSET_W-1:0] base_now = '0;   // reset clears base_offset

	byte_pair_t  pairs_to_send [$];   // filled by the stimulus, drained by the driver
	record_t     records_due   [$];   // record bytes the block owes us, oldest first
	int unsigned mismatches = 0;

	// Absorb one accepted byte pair; on chunk close with any difference,
	// queue one record byte per byte of the chunk.
	task automatic encode_pair(input byte_pair_t p);
		logic [OFFSET_W-1:0] first_pos;
		record_t             rec;
		if (fill_cnt >= CHUNK)
			fill_cnt = 0;
		new_img[fill_cnt] = p.new_b;
		old_img[fill_cnt] = p.old_b;
		if (p.new_b != p.old_b)
			any_diff = 1'b1;
		fill_cnt++;
		if (fill_cnt >= CHUNK || p.eof) begin
			if (any_diff) begin
				// position of the chunk's first byte; offset wraps at 40 bits
				first_pos = file_pos - OFFSET_W'(fill_cnt - 1);
				for (int k = 0; k < fill_cnt; k++) begin
					rec.offset = base_now + first_pos;
					rec.size   = SIZE_BITS'(fill_cnt);
					rec.patch  = new_img[k];
					rec.backup = old_img[k];
					rec.last   = (k + 1 == fill_cnt);
					records_due.push_back(rec);
				end
			end
			fill_cnt = 0;
			any_diff = 1'b0;
		end
		// position restarts after end of file
		file_pos = p.eof ? '0 : file_pos + 1'b1;
	endtask

	// ---- driver: bursts of random length, random gaps between them ----
	int         burst_left = 0;
	int         gap_left   = 0;
	byte_pair_t next_pair;

	always @(posedge clk) begin
		// register write takes effect at this edge; done only with no pair pending, a chunk may be open
		if (cfg_wr_en)
			base_now = cfg_wr_data;
		if (push && !full)
			encode_pair(byte_pair_t'{new_byte, old_byte, end_of_file});
		// a transaction refused by full is held unchanged
		if (!(push && full)) begin
			if (gap_left > 0) begin
				gap_left--;
				push <= 1'b0;
			end else if (pairs_to_send.size() > 0) begin
				next_pair = pairs_to_send.pop_front();
				push        <= 1'b1;
				new_byte    <= next_pair.new_b;
				old_byte    <= next_pair.old_b;
				end_of_file <= next_pair.eof;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 40);
					// a quarter of bursts run straight into the next one
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				push <= 1'b0;
			end
		end
	end

	// ---- monitor: check each popped record byte, then pick next pop ----
	drain_mode_t drain_mode = DRAIN_FULL;
	int          mode_left  = 0;
	record_t     due;

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (records_due.size() == 0) begin
				$error("record byte with nothing due: chunk_offset %h", chunk_offset);
				mismatches++;
			end else begin
				due = records_due.pop_front();
				if (chunk_offset !== due.offset) begin
					$error("chunk_offset: expected %h, got %h", due.offset, chunk_offset);
					mismatches++;
				end
				if (chunk_size !== due.size) begin
					$error("chunk_size: expected %0d, got %0d", due.size, chunk_size);
					mismatches++;
				end
				if (patch_byte !== due.patch) begin
					$error("patch_byte: expected %h, got %h", due.patch, patch_byte);
					mismatches++;
				end
				if (backup_byte !== due.backup) begin
					$error("backup_byte: expected %h, got %h", due.backup, backup_byte);
					mismatches++;
				end
				if (last_of_record !== due.last) begin
					$error("last_of_record: expected %b, got %b", due.last, last_of_record);
					mismatches++;
				end
			end
		end
		if (mode_left <= 0) begin
			drain_mode = drain_mode_t'($urandom_range(0, 3));
			mode_left  = $urandom_range(10, 60);
		end
		mode_left--;
		case (drain_mode)
			DRAIN_FULL:   pop <= 1'b1;
			DRAIN_HALF:   pop <= 1'($urandom_range(0, 1));
			DRAIN_SPARSE: pop <= ($urandom_range(0, 3) == 0);
			default:      pop <= 1'b0;
		endcase
	end

	// ---- stimulus helpers ----
	task automatic add_pair(input logic [BYTE_W-1:0] nb, input logic [BYTE_W-1:0] ob,
			input logic eof);
		pairs_to_send.push_back(byte_pair_t'{nb, ob, eof});
	endtask

	// idle: all pairs accepted, nothing owed, then the pipeline allowed to settle
	task automatic wait_drained();
		while (pairs_to_send.size() != 0 || push || records_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	task automatic write_base(input logic [OFFSET_W-1:0] value);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// one file (or an unterminated piece of one) with random content
	task automatic add_file(input int len, input bit close);
		file_style_t       style;
		int                hit;
		logic [BYTE_W-1:0] nb;
		logic [BYTE_W-1:0] ob;
		style = file_style_t'($urandom_range(0, 3));
		hit   = $urandom_range(0, len - 1);
		for (int i = 0; i < len; i++) begin
			nb = BYTE_W'($urandom);
			ob = nb;
			case (style)
				STYLE_ONE_DIFF: if (i == hit) ob = nb ^ BYTE_W'($urandom_range(1, 255));
				STYLE_NOISE:    ob = BYTE_W'($urandom);
				STYLE_SPARSE:   if ($urandom_range(0, 7) == 0)
					ob = nb ^ BYTE_W'($urandom_range(1, 255));
				default: ;
			endcase
			add_pair(nb, ob, close && (i == len - 1));
		end
	endtask

	// ---- main sequence ----
	initial begin
		logic [OFFSET_W-1:0] phase_base [N_PHASES];
		int unsigned         phase_items;
		int                  len;
		int unsigned         kind;

		phase_base[0] = '0;
		phase_base[1] = {8'($urandom), 32'($urandom)};
		phase_base[2] = 40'hFF_FFFF_FFC0;   // later chunks of a file wrap past 2^40
		phase_base[3] = 40'hFF_FFFF_FFFF;
		phase_base[4] = {8'($urandom), 32'($urandom)};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: one-byte files at the byte extremes, differing and not
		add_pair(8'hFF, 8'h00, 1'b1);
		add_pair(8'h00, 8'h00, 1'b1);
		add_pair(8'h00, 8'hFF, 1'b1);
		add_pair(8'hFF, 8'hFF, 1'b1);
		// short file, difference in the middle
		add_pair(8'h12, 8'h12, 1'b0);
		add_pair(8'hA5, 8'h5A, 1'b0);
		add_pair(8'h00, 8'h00, 1'b1);
		wait_drained();

		// top base offset: chunk offset at the very end of the space
		write_base(40'hFF_FFFF_FFFF);
		add_pair(8'h01, 8'h02, 1'b0);
		add_pair(8'h80, 8'h80, 1'b1);
		// base offset changed while a chunk is open: value at close counts
		add_pair(8'h11, 8'h22, 1'b0);
		add_pair(8'h33, 8'h33, 1'b0);
		wait_drained();
		write_base(40'h00_0000_1000);
		add_pair(8'h44, 8'h45, 1'b1);
		// multi-byte file with every pair equal
		add_pair(8'h7F, 8'h7F, 1'b0);
		add_pair(8'h80, 8'h80, 1'b0);
		add_pair(8'hC3, 8'hC3, 1'b0);
		add_pair(8'h3C, 8'h3C, 1'b1);
		// sender holds off here until every record byte has come
		wait_drained();

		// random phases, one base offset each
		for (int ph = 0; ph < N_PHASES; ph++) begin
			write_base(phase_base[ph]);
			phase_items = 0;
			while (phase_items < PHASE_LEN) begin
				kind = $urandom_range(0, 9);
				if (kind < 6)
					len = $urandom_range(1, 8);
				else if (kind < 8)
					len = $urandom_range(9, 40);
				else if (kind == 8) begin
					// around the chunk boundary, and two whole chunks
					case ($urandom_range(0, 3))
						0:       len = CHUNK - 1;
						1:       len = CHUNK;
						2:       len = CHUNK + 1;
						default: len = 2 * CHUNK;
					endcase
				end else
					len = $urandom_range(CHUNK + 2, 100);
				add_file(len, 1'b1);
				phase_items += len;
			end
			// leave a file open now and then, so the next base lands mid-file
			if (ph != N_PHASES - 1 && $urandom_range(0, 1) == 1)
				add_file($urandom_range(1, 5), 1'b0);
			wait_drained();
		end

		if (mismatches == 0 && records_due.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// watchdog: far beyond the slowest legal run
	initial begin
		#RUN_LIMIT;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
